@@ hw/rtl/dmxp_pkg.sv @@
// Package for the dynamic minimum XOR pair table.
// Holds the word types, operation and status codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package dmxp_pkg;

    localparam int VALUE_BITS = 30;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_ZERO  = 3'd1;
    localparam logic [2:0] IDX_COUNT = 3'd2;
    localparam logic [2:0] IDX_INC   = 3'd3;
    localparam logic [2:0] IDX_DEC   = 3'd4;

    localparam logic [1:0] RD_IDX = 2'd0;
    localparam logic [1:0] RD_DEC = 2'd1;
    localparam logic [1:0] RD_INC = 2'd2;

    typedef struct packed {
        logic [1:0]            op;
        logic [VALUE_BITS-1:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic [VALUE_BITS-1:0] min_xor;
        logic [1:0]            status;
    } t_result_word;

    typedef struct packed {
        logic       load;
        logic [2:0] idx_mode;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_rdata;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       min_clr;
        logic       min_upd;
        logic       prev_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic                  full;
        logic                  lt2;
        logic                  idx_zero;
        logic                  idx_eq_cnt;
        logic                  idx_last;
        logic                  ge;
        logic                  eq;
        logic [VALUE_BITS-1:0] min_xor;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/dynamic_min_xor_pair_table.sv @@
// Top level of the dynamic minimum XOR pair table.
// Joins dmxp_ctrl and dmxp_datapath; depends on dmxp_pkg.
`default_nettype none

// Usage
// A command word (op, value) is taken at a rising edge where i_start is high
// and o_busy is low. Op insert adds value to a sorted multiset, op remove
// takes out one copy of value, op query returns the smallest XOR of any two
// stored values. Any other op code changes nothing and answers ok with zero.
// Exactly one result word (min_xor, status) follows each command: it sits on
// o_result for one cycle with o_strobe high. The receiver cannot stall it.
// Timing is set by the single memory port. Each command works through it in steps:
//   insert: shifts larger values up from the top down, and the value lands in
//           the freed slot or at slot zero;
//   remove: searches for the value, then shifts the rest down when found;
//   query:  walks all neighbour pairs;
// a full table, a short table and the spare op code go straight to the result.
// o_busy stays high from acceptance until the result cycle, in which the
// next word may already be taken. Reset empties the table at once (the count
// clears); no clearing pass runs over the memory.

module dynamic_min_xor_pair_table #(
    parameter int CAPACITY = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire dmxp_pkg::t_cmd_word i_cmd,
    output logic                     o_busy,
    output logic                     o_strobe,
    output dmxp_pkg::t_result_word   o_result
);

    dmxp_pkg::t_dp_cmd  dp_cmd;
    dmxp_pkg::t_dp_stat dp_stat;

    dmxp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_word   (i_cmd),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    dmxp_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_word  (i_cmd),
        .o_stat  (dp_stat)
    );

    // A result lasts one cycle only.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // An accepted word always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not make the block busy");

    // Any error status carries a zero minimum.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != dmxp_pkg::ST_OK)) |-> (o_result.min_xor == '0))
        else $error("error result with non-zero minimum");

endmodule

`default_nettype wire

@@ hw/rtl/dmxp_datapath.sv @@
// Datapath of the minimum XOR pair table: sorted value memory, index, count,
// previous value and running minimum. Depends on dmxp_pkg.
`default_nettype none

module dmxp_datapath #(
    parameter int CAPACITY = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire dmxp_pkg::t_dp_cmd   i_cmd,
    input  wire dmxp_pkg::t_cmd_word i_word,
    output dmxp_pkg::t_dp_stat       o_stat
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VB = dmxp_pkg::VALUE_BITS;

    logic [VB-1:0] r_mem [CAPACITY];
    logic [VB-1:0] r_rdata;
    logic [VB-1:0] r_val;
    logic [VB-1:0] r_prev;
    logic [VB-1:0] r_min;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] idx_p1;
    logic [VB-1:0] pair_x;

    assign idx_p1 = r_idx + CW'(1);
    assign pair_x = r_prev ^ r_rdata;

    always_comb begin
        case (i_cmd.rd_sel)
            dmxp_pkg::RD_DEC: rd_addr = r_idx - CW'(1);
            dmxp_pkg::RD_INC: rd_addr = idx_p1;
            default:          rd_addr = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.idx_mode)
            dmxp_pkg::IDX_ZERO:  n_idx = '0;
            dmxp_pkg::IDX_COUNT: n_idx = r_cnt;
            dmxp_pkg::IDX_INC:   n_idx = idx_p1;
            dmxp_pkg::IDX_DEC:   n_idx = r_idx - CW'(1);
            default:             n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
        if (i_cmd.wr_en) begin
            r_mem[r_idx[AW-1:0]] <= i_cmd.wr_rdata ? r_rdata : r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_val <= i_word.value;
        end
        if (i_cmd.prev_ld) begin
            r_prev <= r_rdata;
        end
        if (i_cmd.min_clr) begin
            r_min <= '1;
        end else if (i_cmd.min_upd && (pair_x < r_min)) begin
            r_min <= pair_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_stat.full       = (r_cnt >= CW'(CAPACITY));
    assign o_stat.lt2        = (r_cnt < CW'(2));
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.idx_eq_cnt = (r_idx == r_cnt);
    assign o_stat.idx_last   = (idx_p1 >= r_cnt);
    assign o_stat.ge         = (r_rdata >= r_val);
    assign o_stat.eq         = (r_rdata == r_val);
    assign o_stat.min_xor    = r_min;

endmodule

`default_nettype wire

@@ hw/rtl/dmxp_ctrl.sv @@
// Controller state machine of the minimum XOR pair table: sequences insert,
// remove and query over the datapath and registers the result. Depends on dmxp_pkg.
`default_nettype none

module dmxp_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire dmxp_pkg::t_cmd_word i_word,
    input  wire dmxp_pkg::t_dp_stat  i_stat,
    output dmxp_pkg::t_dp_cmd        o_cmd,
    output logic                     o_busy,
    output logic                     o_strobe,
    output dmxp_pkg::t_result_word   o_result
);

    typedef enum logic [3:0] {
        S_IDLE, S_I_RD, S_I_CMP, S_R_RD, S_R_CMP, S_R_SH, S_R_WR,
        S_Q_RD0, S_Q_FIRST, S_Q_RD, S_Q_ACC, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_qok, n_qok;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_status = r_status;
        n_qok    = r_qok;
        case (r_state)
            S_IDLE: begin
                n_qok = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_status   = dmxp_pkg::ST_OK;
                    n_state    = S_DONE;
                    case (i_word.op)
                        dmxp_pkg::OP_INSERT: begin
                            if (i_stat.full) begin
                                n_status = dmxp_pkg::ST_FULL;
                            end else begin
                                o_cmd.idx_mode = dmxp_pkg::IDX_COUNT;
                                n_state        = S_I_RD;
                            end
                        end
                        dmxp_pkg::OP_REMOVE: begin
                            o_cmd.idx_mode = dmxp_pkg::IDX_ZERO;
                            n_state        = S_R_RD;
                        end
                        dmxp_pkg::OP_QUERY: begin
                            if (i_stat.lt2) begin
                                n_status = dmxp_pkg::ST_FEW;
                            end else begin
                                o_cmd.idx_mode = dmxp_pkg::IDX_ZERO;
                                o_cmd.min_clr  = 1'b1;
                                n_state        = S_Q_RD0;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_I_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = dmxp_pkg::RD_DEC;
                    n_state      = S_I_CMP;
                end
            end
            S_I_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.ge) begin
                    o_cmd.wr_rdata = 1'b1;
                    o_cmd.idx_mode = dmxp_pkg::IDX_DEC;
                    n_state        = S_I_RD;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_R_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    n_status = dmxp_pkg::ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_R_CMP;
                end
            end
            S_R_CMP: begin
                if (!i_stat.ge) begin
                    o_cmd.idx_mode = dmxp_pkg::IDX_INC;
                    n_state        = S_R_RD;
                end else if (i_stat.eq) begin
                    n_state = S_R_SH;
                end else begin
                    n_status = dmxp_pkg::ST_ABSENT;
                    n_state  = S_DONE;
                end
            end
            S_R_SH: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = dmxp_pkg::RD_INC;
                    n_state      = S_R_WR;
                end
            end
            S_R_WR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_rdata = 1'b1;
                o_cmd.idx_mode = dmxp_pkg::IDX_INC;
                n_state        = S_R_SH;
            end
            S_Q_RD0: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.idx_mode = dmxp_pkg::IDX_INC;
                n_state        = S_Q_FIRST;
            end
            S_Q_FIRST: begin
                o_cmd.prev_ld = 1'b1;
                n_state       = S_Q_RD;
            end
            S_Q_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.idx_mode = dmxp_pkg::IDX_INC;
                n_state        = S_Q_ACC;
            end
            S_Q_ACC: begin
                o_cmd.min_upd = 1'b1;
                o_cmd.prev_ld = 1'b1;
                if (i_stat.idx_eq_cnt) begin
                    n_qok   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= dmxp_pkg::ST_OK;
            r_qok    <= 1'b0;
            o_strobe <= 1'b0;
            o_result <= '0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_qok    <= n_qok;
            o_strobe <= (r_state == S_DONE);
            if (r_state == S_DONE) begin
                o_result.status  <= r_status;
                o_result.min_xor <= r_qok ? i_stat.min_xor : '0;
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the dynamic minimum XOR pair table.
// Drives insert, remove, query and spare commands and checks every result word
// against a behavioural copy of the sorted multiset; depends on dmxp_pkg and the RTL.
`default_nettype none

module testbench;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = dmxp_pkg::VALUE_BITS;
    localparam int WATCH_MAX  = 40000;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    dmxp_pkg::t_cmd_word    i_cmd = '0;
    logic                   o_busy;
    logic                   o_strobe;
    dmxp_pkg::t_result_word o_result;

    dynamic_min_xor_pair_table #(.CAPACITY(CAPACITY)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    // Words waiting to be sent, and the result words that are owed.
    dmxp_pkg::t_cmd_word    pending_cmds[$];
    dmxp_pkg::t_result_word owed_results[$];
    int           total_cmds = 0;
    int           sent_cmds = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    // The table as it should be: stored values kept in ascending order.
    logic [VALUE_BITS-1:0] table_model[$];

    // Generator-side view of the stored values, used to pick removes that hit.
    logic [VALUE_BITS-1:0] gen_present[$];

    function automatic int first_not_below(logic [VALUE_BITS-1:0] v);
        int slot;
        slot = 0;
        while (slot < table_model.size() && table_model[slot] < v) slot++;
        return slot;
    endfunction

    // Applies one accepted word to the modelled table and returns the answer.
    function automatic dmxp_pkg::t_result_word apply_cmd(dmxp_pkg::t_cmd_word w);
        dmxp_pkg::t_result_word r;
        int slot;
        r = '0;
        r.status = dmxp_pkg::ST_OK;
        case (w.op)
            dmxp_pkg::OP_INSERT: begin
                if (table_model.size() >= CAPACITY) begin
                    r.status = dmxp_pkg::ST_FULL;
                end else begin
                    slot = first_not_below(w.value);
                    table_model.insert(slot, w.value);
                end
            end
            dmxp_pkg::OP_REMOVE: begin
                slot = first_not_below(w.value);
                if (slot >= table_model.size() || table_model[slot] != w.value) begin
                    r.status = dmxp_pkg::ST_ABSENT;
                end else begin
                    table_model.delete(slot);
                end
            end
            dmxp_pkg::OP_QUERY: begin
                if (table_model.size() < 2) begin
                    r.status = dmxp_pkg::ST_FEW;
                end else begin
                    // Neighbours in sorted order always hold the smallest XOR.
                    r.min_xor = table_model[0] ^ table_model[1];
                    for (int k = 1; k + 1 < table_model.size(); k++) begin
                        if ((table_model[k] ^ table_model[k+1]) < r.min_xor) begin
                            r.min_xor = table_model[k] ^ table_model[k+1];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_cmd(logic [1:0] op, logic [VALUE_BITS-1:0] v);
        dmxp_pkg::t_cmd_word w;
        int idx;
        w.op = op;
        w.value = v;
        pending_cmds.push_back(w);
        if (op == dmxp_pkg::OP_INSERT) begin
            gen_present.push_back(v);
        end else if (op == dmxp_pkg::OP_REMOVE) begin
            idx = -1;
            foreach (gen_present[k]) if (idx < 0 && gen_present[k] == v) idx = k;
            if (idx >= 0) gen_present.delete(idx);
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        case ($urandom_range(3))
            0: return VALUE_BITS'($urandom_range(63));
            1: return VALUE_BITS'($urandom);
            2: return VALUE_MAX - VALUE_BITS'($urandom_range(63));
            default: return VALUE_BITS'($urandom_range(4095)) << $urandom_range(18);
        endcase
    endfunction

    // Driver: the word on i_cmd is held until a rising edge with o_busy low.
    always @(posedge i_clk) begin
        logic     take;
        int       idle_pct;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            take = i_start && !o_busy;
            if (take) begin
                owed_results.push_back(apply_cmd(i_cmd));
                sent_cmds++;
            end
            if (take || !i_start) begin
                // Sender idles 31 per cent of cycles, then 47, then not at all.
                if (sent_cmds < total_cmds / 3) idle_pct = 31;
                else if (sent_cmds < 2 * total_cmds / 3) idle_pct = 47;
                else idle_pct = 0;
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_start <= 1'b1;
                    i_cmd <= pending_cmds.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: each strobed word is compared with the oldest owed result.
    always @(posedge i_clk) begin
        dmxp_pkg::t_result_word want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result word", 32'(o_result), 32'd0);
            end else begin
                want = owed_results.pop_front();
                if (o_result.min_xor !== want.min_xor) begin
                    report_mismatch("min_xor", 32'(o_result.min_xor), 32'(want.min_xor));
                end
                if (o_result.status !== want.status) begin
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n_random;
        int pick;
        logic [VALUE_BITS-1:0] v;

        // Directed words: empty-table errors, extremes, duplicates, spare op.
        queue_cmd(dmxp_pkg::OP_QUERY, VALUE_MAX);
        queue_cmd(dmxp_pkg::OP_REMOVE, '0);
        queue_cmd(dmxp_pkg::OP_INSERT, '0);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);
        queue_cmd(dmxp_pkg::OP_INSERT, VALUE_MAX);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);
        queue_cmd(dmxp_pkg::OP_INSERT, '0);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);
        queue_cmd(dmxp_pkg::OP_REMOVE, '0);
        queue_cmd(dmxp_pkg::OP_REMOVE, '0);
        queue_cmd(dmxp_pkg::OP_REMOVE, '0);
        queue_cmd(OP_SPARE, VALUE_MAX);
        queue_cmd(dmxp_pkg::OP_INSERT, 30'h2AAAAAAA);
        queue_cmd(dmxp_pkg::OP_INSERT, 30'h15555555);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);
        queue_cmd(dmxp_pkg::OP_REMOVE, 30'h2AAAAAAB);
        queue_cmd(dmxp_pkg::OP_REMOVE, VALUE_MAX);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);
        queue_cmd(dmxp_pkg::OP_REMOVE, 30'h2AAAAAAA);
        queue_cmd(dmxp_pkg::OP_REMOVE, 30'h15555555);
        queue_cmd(dmxp_pkg::OP_QUERY, '0);

        // Random words; removes mostly hit a stored copy, and the table is kept
        // to a few dozen entries so that shifts and scans stay short.
        n_random = 560;
        for (int k = 0; k < n_random; k++) begin
            pick = $urandom_range(99);
            if (gen_present.size() < 3 && pick < 60) pick = 0;
            if (gen_present.size() > 48 && pick < 45) pick = 50;
            if (pick < 42) begin
                queue_cmd(dmxp_pkg::OP_INSERT, random_value());
            end else if (pick < 72) begin
                if (gen_present.size() > 0 && $urandom_range(4) != 0) begin
                    v = gen_present[$urandom_range(gen_present.size() - 1)];
                end else begin
                    v = random_value();
                end
                queue_cmd(dmxp_pkg::OP_REMOVE, v);
            end else if (pick < 95) begin
                queue_cmd(dmxp_pkg::OP_QUERY, VALUE_BITS'($urandom));
            end else begin
                queue_cmd(OP_SPARE, VALUE_BITS'($urandom));
            end
        end

        total_cmds = pending_cmds.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && sent_cmds == total_cmds && owed_results.size() == 0);
        // Allow time for any stray result word to show itself.
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/dmxp_pkg.sv
hw/rtl/dmxp_datapath.sv
hw/rtl/dmxp_ctrl.sv
hw/rtl/dynamic_min_xor_pair_table.sv
tb/testbench.sv
